// ===== rtl/core/ptcs_pkg.sv =====
package ptcs_pkg;

  localparam int TimeW   = 63;
  localparam int PeriodW = 40;
  localparam int SlotW   = 3;
  localparam int MaskW   = 8;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  // action codes
  localparam logic [1:0] ActTick   = 2'd0;
  localparam logic [1:0] ActReg    = 2'd1;
  localparam logic [1:0] ActRemove = 2'd2;

  typedef struct packed {
    logic [1:0]         action;
    logic [TimeW-1:0]   tick_time;
    logic [SlotW-1:0]   channel_slot;
    logic [PeriodW-1:0] period_ns;
  } in_t;

  typedef struct packed {
    logic [MaskW-1:0] fired_mask;
    logic [TimeW-1:0] earliest_due;
    logic             none_active;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_DIV,
    ST_WB,
    ST_DONE
  } state_t;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic [TimeW-1:0]   dividend;
    logic [PeriodW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [PeriodW-1:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/core/ptcs_div.sv =====
module ptcs_div (
  input  logic                clk,
  input  logic                rst_n,
  input  ptcs_pkg::div_req_t  req,
  output ptcs_pkg::div_rsp_t  rsp
);
  import ptcs_pkg::*;

  logic [TimeW-1:0]   dvd_r;
  logic [PeriodW-1:0] div_r;
  logic [PeriodW-1:0] rem_r;
  logic [5:0]         cnt_r;
  logic               busy_r;
  logic               done_r;
  logic [PeriodW:0]   trial;

  // restoring step: one quotient bit per cycle, only the remainder is kept
  assign trial = {rem_r, dvd_r[TimeW-1]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'(TimeW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      div_r <= req.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[TimeW-2:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_r <= PeriodW'(trial - {1'b0, div_r});
      end else begin
        rem_r <= trial[PeriodW-1:0];
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

// ===== rtl/core/periodic_timer_channel_scheduler.sv =====
// Channel   Ports                      Direction  Transaction
// command   start, busy, in_data       in         start & !busy at a rising edge
// result    out_valid, out_data        out        out_valid high for one cycle
//
// Every command runs one sweep over all CHANNELS slots, each slot taking a
// memory read and an evaluate state. On a tick an active slot that is due or
// too far ahead also runs the shared remainder divider (63 restoring steps
// and a done pulse) and then a write-back. Reset (synchronous, rst_n low)
// clears the active bits and the sequencer. The receiver cannot stall.
module periodic_timer_channel_scheduler #(
  parameter int CHANNELS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  ptcs_pkg::in_t   in_data,
  output logic            out_valid,
  output ptcs_pkg::out_t  out_data
);
  import ptcs_pkg::*;

  localparam int IW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  state_t state_r, state_nxt;

  in_t                in_r;
  logic [IW-1:0]      idx_r;
  logic [CHANNELS-1:0] act_r;
  logic [MaskW-1:0]   mask_r;
  logic [TimeW-1:0]   min_r;
  logic               any_r;

  // slot memories
  logic [PeriodW-1:0] per_mem [CHANNELS];
  logic [TimeW-1:0]   due_mem [CHANNELS];
  logic [PeriodW-1:0] rd_per_r;
  logic [TimeW-1:0]   rd_due_r;

  logic               accept;
  logic               slot_ok;
  logic               last_slot;
  logic               cur_act;
  logic               is_due;
  logic               too_far;
  logic [TimeW:0]     nm_wide;
  logic [TimeW-1:0]   nm;
  logic [6:0]         idx7;
  logic               we;
  logic [IW-1:0]      waddr;
  div_req_t           dreq;
  div_rsp_t           drsp;

  assign accept    = start && !busy;
  assign slot_ok   = {4'd0, in_data.channel_slot} < 7'(CHANNELS);
  assign last_slot = idx_r == IW'(CHANNELS - 1);
  assign cur_act   = act_r[idx_r];
  assign idx7      = 7'(idx_r);

  // due checks against the tick time
  assign is_due  = rd_due_r <= in_r.tick_time;
  assign too_far = {1'b0, rd_due_r} >
                   ({1'b0, in_r.tick_time} + {{(TimeW+1-PeriodW){1'b0}}, rd_per_r});

  // next multiple above t is t - (t mod p) + p, saturated
  assign nm_wide = {1'b0, in_r.tick_time}
                 - {{(TimeW+1-PeriodW){1'b0}}, drsp.rem}
                 + {{(TimeW+1-PeriodW){1'b0}}, rd_per_r};
  assign nm = nm_wide[TimeW] ? TimeMax : nm_wide[TimeW-1:0];

  ptcs_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EVAL;
      ST_EVAL: begin
        if (in_r.action == ActTick && cur_act && (is_due || too_far)) begin
          state_nxt = ST_DIV;
        end else if (last_slot) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_DIV:  if (drsp.done) state_nxt = ST_WB;
      ST_WB:   state_nxt = last_slot ? ST_DONE : ST_READ;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy          = state_r != ST_IDLE;
    out_valid     = state_r == ST_DONE;
    dreq.start    = (state_r == ST_EVAL) && (state_nxt == ST_DIV);
    dreq.dividend = in_r.tick_time;
    dreq.divisor  = rd_per_r;
  end

  // memory write port: register command or tick write-back
  assign we    = (accept && in_data.action == ActReg && slot_ok) || (state_r == ST_WB);
  assign waddr = (state_r == ST_WB) ? idx_r : IW'(in_data.channel_slot);

  always_ff @(posedge clk) begin
    if (we) begin
      if (state_r == ST_WB) begin
        due_mem[waddr] <= nm;
      end else begin
        due_mem[waddr] <= '0;
        per_mem[waddr] <= (in_data.period_ns == '0) ? PeriodW'(1) : in_data.period_ns;
      end
    end
    rd_due_r <= due_mem[idx_r];
    rd_per_r <= per_mem[idx_r];
  end

  // control and sweep state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      act_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept && slot_ok) begin
        if (in_data.action == ActReg) begin
          act_r[IW'(in_data.channel_slot)] <= 1'b1;
        end else if (in_data.action == ActRemove) begin
          act_r[IW'(in_data.channel_slot)] <= 1'b0;
        end
      end
      if (accept) begin
        idx_r <= '0;
      end else if ((state_r == ST_EVAL && state_nxt != ST_DIV && !last_slot) ||
                   (state_r == ST_WB && !last_slot)) begin
        idx_r <= idx_r + IW'(1);
      end
    end
  end

  // result accumulation
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r   <= in_data;
      mask_r <= '0;
      min_r  <= TimeMax;
      any_r  <= 1'b0;
    end else if (state_r == ST_EVAL && state_nxt != ST_DIV && cur_act) begin
      any_r <= 1'b1;
      if (rd_due_r < min_r) min_r <= rd_due_r;
    end else if (state_r == ST_WB) begin
      any_r <= 1'b1;
      if (nm < min_r) min_r <= nm;
      if (is_due && idx7 < 7'(MaskW)) mask_r[idx7[2:0]] <= 1'b1;
    end
  end

  assign out_data.fired_mask   = mask_r;
  assign out_data.earliest_due = min_r;
  assign out_data.none_active  = !any_r;

endmodule
